// ===== hdl/drpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Dead-reckoning pose integrator package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package drpi_pkg;

	localparam int unsigned TsReset     = 6554;
	localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
	localparam logic [31:0] CordicStart = 32'd652032874;
	localparam int unsigned AtanDepth   = 24;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== hdl/dead_reckoning_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// Dead-reckoning pose integrator
// Unicycle odometry: speed and yaw rate in, saturated pose and quaternion out.
// ----------------------------------------------------------------------------
// One command beat is handled at a time. Every multiply runs on one
// shift-and-add unit that consumes one multiplier bit per cycle and stops
// early once the remaining multiplier bits are zero. Each CORDIC run uses
// one shared rotation stage. In the worst case a command passes through:
// speed*time_step, old-heading CORDIC, a launch state, two position
// products (the forward step stays below 2^31), an accumulate state, yaw
// product, binary-angle conversion, a heading update, a launch state,
// half-angle CORDIC and the load of the output register. The next command
// beat can be accepted once the block returns to idle, even while the
// previous result still waits on m_axis_tready; that command then holds in
// its final state until the output register is free. The position
// accumulators saturate at the signed 32-bit range; the heading wraps as a
// binary angle. time_step is written through the cfg channel only while the
// block is idle and no command beat is offered.
module dead_reckoning_pose_integrator
	import drpi_pkg::*;
#(
	parameter int CORDIC_STEPS = 16,
	parameter int HEADING_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] linear_speed, [31:16] turn_rate
	input  logic [31:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] pos_x, [63:32] pos_y, [79:64] heading, [95:80] quat_z,
	// [111:96] quat_w, [127:112] speed_echo, [143:128] rate_echo
	output logic [143:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int HB = HEADING_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MSTEP, ST_CORD1, ST_LX, ST_MX, ST_MY, ST_ACC,
		ST_MYAW, ST_MANG, ST_HUPD, ST_CORD2, ST_OUT
	} state_t;

	state_t       state_q;
	logic [15:0]  ts_q;
	logic signed [31:0] x_q, y_q;
	logic [HB-1:0] head_q;
	logic [15:0]  spd_q, rate_q;
	logic [5:0]   cnt_q;
	// Serial multiplier: unsigned magnitudes, product sign held separately.
	logic [63:0]  acc_q;
	logic [33:0]  mcand_q;
	logic [33:0]  mplr_q;
	logic         neg_q;
	logic [63:0]  step_q;   // |speed*ts|, sign in step_neg_q
	logic         step_neg_q;
	logic signed [32:0] dx_q, dy_q;
	// CORDIC
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic         flip_q;
	logic signed [33:0] cos_q, sin_q;
	logic [143:0] out_q;
	logic         ovalid_q;

	// Top 32 bits of the heading as a binary angle. It is the old heading
	// until the update state and the new heading from then on.
	logic [31:0] ang_old;
	if (HB >= 32) begin : g_ang_wide
		assign ang_old = head_q[HB-1 -: 32];
	end else begin : g_ang_narrow
		assign ang_old = {head_q, {(32-HB){1'b0}}};
	end

	// One CORDIC rotation per cycle.
	logic signed [33:0] dxs, dys;
	logic [31:0] at;
	logic signed [33:0] cord_x_nx, cord_y_nx, cord_z_nx;
	always_comb begin
		dxs = cy_q >>> cnt_q[4:0];
		dys = cx_q >>> cnt_q[4:0];
		at  = atan_turns(cnt_q[4:0]);
		cord_x_nx = cz_q[33] ? cx_q + dxs : cx_q - dxs;
		cord_y_nx = cz_q[33] ? cy_q - dys : cy_q + dys;
		cord_z_nx = cz_q[33] ? cz_q + 34'(at) : cz_q - 34'(at);
	end

	// One shift-and-add step of the multiplier.
	logic [63:0] mul_nx;
	logic        mul_done;
	always_comb begin
		mul_nx   = mplr_q[0] ? acc_q + (64'(mcand_q) << cnt_q) : acc_q;
		mul_done = (cnt_q == 6'd33) || (mplr_q[33:1] == '0);
	end

	// Prepare CORDIC start from a 32-bit angle.
	function automatic logic [68:0] cord_init(input logic [31:0] a);
		logic signed [33:0] z;
		logic f;
		begin
			z = 34'(signed'(a));
			f = 1'b0;
			if (z > 34'sh40000000) begin
				z = z - 34'sh80000000;
				f = 1'b1;
			end else if (z < -34'sh40000000) begin
				z = z + 34'sh80000000;
				f = 1'b1;
			end
			return {f, z, 34'(CordicStart)};
		end
	endfunction

	// Rounded signed result of |m| >> s, ties away from zero.
	function automatic logic signed [33:0] rnd(input logic [63:0] m, input logic n,
			input int s);
		logic [63:0] r;
		begin
			r = (m + (64'd1 << (s - 1))) >> s;
			return n ? -34'(r) : 34'(r);
		end
	endfunction

	function automatic logic signed [15:0] clampq(input logic signed [33:0] v);
		logic signed [33:0] r;
		begin
			r = v;
			if (r > 34'sd16384) r = 34'sd16384;
			if (r < -34'sd16384) r = -34'sd16384;
			return r[15:0];
		end
	endfunction

	logic signed [33:0] sum_x, sum_y;
	always_comb begin
		sum_x = 34'(x_q) + 34'(dx_q);
		sum_y = 34'(y_q) + 34'(dy_q);
	end

	logic [HB-1:0] delta;
	always_comb begin
		logic [63:0] r;
		r = (acc_q + (64'd1 << (59 - HB))) >> (60 - HB);
		delta = neg_q ? HB'(-r) : HB'(r);
	end

	// The finished result moves into the output register once it is free.
	logic out_fire;
	assign out_fire = (state_q == ST_OUT) && (cnt_q == 6'd0)
		&& (!ovalid_q || m_axis_tready);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE) && !s_axis_tvalid;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ts_q     <= 16'(TsReset);
			x_q      <= '0;
			y_q      <= '0;
			head_q   <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (out_fire) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) ts_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						spd_q   <= s_axis_tdata[15:0];
						rate_q  <= s_axis_tdata[31:16];
						neg_q   <= s_axis_tdata[15];
						mcand_q <= 34'(s_axis_tdata[15]
							? 16'(-s_axis_tdata[15:0]) : s_axis_tdata[15:0]);
						mplr_q  <= 34'(ts_q);
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_MSTEP;
					end
				end
				ST_MSTEP, ST_MX, ST_MY, ST_MYAW, ST_MANG: begin
					if (!mul_done) begin
						acc_q  <= mul_nx;
						mplr_q <= mplr_q >> 1;
						cnt_q  <= cnt_q + 6'd1;
					end else begin
						cnt_q <= '0;
						case (state_q)
							ST_MSTEP: begin
								step_q     <= mul_nx;
								step_neg_q <= neg_q;
								{flip_q, cz_q, cx_q} <= cord_init(ang_old);
								cy_q    <= '0;
								state_q <= ST_CORD1;
							end
							ST_MX: begin
								dx_q    <= 33'(rnd(mul_nx, neg_q, 38));
								neg_q   <= step_neg_q ^ sin_q[33];
								mcand_q <= sin_q[33] ? -sin_q : sin_q;
								mplr_q  <= 34'(step_q);
								acc_q   <= '0;
								state_q <= ST_MY;
							end
							ST_MY: begin
								dy_q    <= 33'(rnd(mul_nx, neg_q, 38));
								state_q <= ST_ACC;
							end
							ST_MYAW: begin
								mcand_q <= 34'(InvTwoPiQ32);
								mplr_q  <= 34'(mul_nx);
								acc_q   <= '0;
								state_q <= ST_MANG;
							end
							default: begin
								acc_q   <= mul_nx;
								state_q <= ST_HUPD;
							end
						endcase
					end
				end
				ST_CORD1, ST_CORD2: begin
					if (cnt_q != 6'(CORDIC_STEPS - 1)) begin
						cx_q  <= cord_x_nx;
						cy_q  <= cord_y_nx;
						cz_q  <= cord_z_nx;
						cnt_q <= cnt_q + 6'd1;
					end else begin
						cnt_q   <= '0;
						cos_q   <= flip_q ? -cord_x_nx : cord_x_nx;
						sin_q   <= flip_q ? -cord_y_nx : cord_y_nx;
						state_q <= (state_q == ST_CORD1) ? ST_LX : ST_OUT;
					end
				end
				ST_LX: begin
					// Launch the x product from the old-heading cosine.
					neg_q   <= step_neg_q ^ cos_q[33];
					mcand_q <= cos_q[33] ? -cos_q : cos_q;
					mplr_q  <= 34'(step_q);
					acc_q   <= '0;
					state_q <= ST_MX;
				end
				ST_ACC: begin
					if (sum_x > 34'sh7FFFFFFF) x_q <= 32'sh7FFFFFFF;
					else if (sum_x < -34'sh80000000) x_q <= 32'sh80000000;
					else x_q <= sum_x[31:0];
					if (sum_y > 34'sh7FFFFFFF) y_q <= 32'sh7FFFFFFF;
					else if (sum_y < -34'sh80000000) y_q <= 32'sh80000000;
					else y_q <= sum_y[31:0];
					neg_q   <= rate_q[15];
					mcand_q <= 34'(rate_q[15] ? 16'(-rate_q) : rate_q);
					mplr_q  <= 34'(ts_q);
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= (ts_q == '0) ? ST_HUPD : ST_MYAW;
				end
				ST_HUPD: begin
					head_q  <= head_q + delta;
					state_q <= ST_OUT;
					cnt_q   <= 6'd1;
				end
				ST_OUT: begin
					if (cnt_q == 6'd1) begin
						// Half of the new heading for the quaternion.
						{flip_q, cz_q, cx_q} <= cord_init({1'b0, ang_old[31:1]});
						cy_q    <= '0;
						cnt_q   <= '0;
						state_q <= ST_CORD2;
					end else if (out_fire) begin
						out_q <= {rate_q, spd_q, clampq(rnd(cos_q[33] ? 64'(-cos_q) : 64'(cos_q),
							cos_q[33], 16)), clampq(rnd(sin_q[33] ? 64'(-sin_q) : 64'(sin_q),
							sin_q[33], 16)), ang_old[31:16], y_q, x_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register is never overwritten while its beat is pending.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_MSTEP)
		else $error("accepted command did not start");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cfg_ready)
		else $error("config open while busy");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Pose integrator testbench
// Streams speed and yaw-rate commands into the odometry block and checks
// every pose beat against an in-bench fixed-point dead-reckoning predictor,
// across several time-step settings and flow-control patterns.
// ----------------------------------------------------------------------------
module tb
	import drpi_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned SettleCycles = 400;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [15:0] linear_speed, [31:16] turn_rate
	logic [31:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [31:0] pos_x, [63:32] pos_y, [79:64] heading, [95:80] quat_z,
	// [111:96] quat_w, [127:112] speed_echo, [143:128] rate_echo
	logic [143:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	dead_reckoning_pose_integrator #(
		.CORDIC_STEPS(16),
		.HEADING_BITS(32)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Predictor state: Q16.16 position, 32-bit binary heading, time step.
	longint      pose_x;
	longint      pose_y;
	logic [31:0] pose_heading;
	logic [15:0] pose_ts;

	// Expected pose beats, oldest first.
	logic [143:0] pose_queue[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;

	// Arctangent of 2^-i as a 32-bit binary angle.
	logic [31:0] atan_lut[16] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	always #1 clk = ~clk;

	// Rounds v / 2^s to nearest, with ties going away from zero.
	function automatic longint round_away(input longint v, input int s);
		longint m;
		begin
			m = (v < 0) ? -v : v;
			m = (m + (64'sd1 <<< (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		end
	endfunction

	function automatic longint sat_q16(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp_q14(input longint v);
		if (v > 16384)
			return 16384;
		if (v < -16384)
			return -16384;
		return v;
	endfunction

	// Cosine and sine of a binary angle, Q2.30, by a 16-step CORDIC.
	// Angles past a quarter turn are folded by a half turn and negated.
	task automatic cordic_rotate(input logic [31:0] ang, output longint c,
			output longint s);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit     flip;
		begin
			z = longint'($signed(ang));
			x = 64'sd652032874;
			y = 0;
			flip = 1'b0;
			if (z > (64'sd1 <<< 30)) begin
				z = z - (64'sd1 <<< 31);
				flip = 1'b1;
			end else if (z < -(64'sd1 <<< 30)) begin
				z = z + (64'sd1 <<< 31);
				flip = 1'b1;
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(atan_lut[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(atan_lut[i]);
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		end
	endtask

	// Advances the pose by one command and returns the beat it should cause.
	task automatic integrate_pose(input logic [15:0] speed, input logic [15:0] rate,
			output logic [143:0] beat);
		longint c;
		longint s;
		longint step;
		longint yaw;
		longint mag;
		longint qw;
		longint qz;
		logic [31:0] delta;
		begin
			// Position moves along the heading held before this command.
			cordic_rotate(pose_heading, c, s);
			step = longint'($signed(speed)) * longint'(pose_ts);
			pose_x = sat_q16(pose_x + round_away(step * c, 38));
			pose_y = sat_q16(pose_y + round_away(step * s, 38));
			// Yaw in Q4.28 radians, scaled by 1/(2 pi) to a binary angle.
			yaw = longint'($signed(rate)) * longint'(pose_ts);
			mag = (yaw < 0) ? -yaw : yaw;
			mag = (mag * 64'sd683565276 + (64'sd1 <<< 27)) >>> 28;
			delta = (yaw < 0) ? 32'(-mag) : 32'(mag);
			pose_heading = pose_heading + delta;
			// The quaternion uses half the new heading.
			cordic_rotate({1'b0, pose_heading[31:1]}, qw, qz);
			qw = clamp_q14(round_away(qw, 16));
			qz = clamp_q14(round_away(qz, 16));
			beat = {rate, speed, 16'(qw), 16'(qz), pose_heading[31:16],
				32'(pose_y), 32'(pose_x)};
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
		error_count++;
	endtask

	// Result side: check each accepted beat, then pick the next tready.
	always @(posedge clk) begin
		logic [143:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pose_queue.size() == 0) begin
				$display("unexpected pose beat at cycle %0d", cycle_count);
				error_count++;
			end else begin
				want = pose_queue.pop_front();
				if (m_axis_tdata[31:0] !== want[31:0])
					report_mismatch("pos_x", m_axis_tdata[31:0], want[31:0]);
				if (m_axis_tdata[63:32] !== want[63:32])
					report_mismatch("pos_y", m_axis_tdata[63:32], want[63:32]);
				if (m_axis_tdata[79:64] !== want[79:64])
					report_mismatch("heading", 32'(m_axis_tdata[79:64]),
						32'(want[79:64]));
				if (m_axis_tdata[95:80] !== want[95:80])
					report_mismatch("quat_z", 32'(m_axis_tdata[95:80]),
						32'(want[95:80]));
				if (m_axis_tdata[111:96] !== want[111:96])
					report_mismatch("quat_w", 32'(m_axis_tdata[111:96]),
						32'(want[111:96]));
				if (m_axis_tdata[127:112] !== want[127:112])
					report_mismatch("speed_echo", 32'(m_axis_tdata[127:112]),
						32'(want[127:112]));
				if (m_axis_tdata[143:128] !== want[143:128])
					report_mismatch("rate_echo", 32'(m_axis_tdata[143:128]),
						32'(want[143:128]));
			end
		end
		if (hold_cycles != 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted down on its own.
	always @(posedge clk) begin
		if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one command beat after a random idle gap and predicts its pose.
	// tvalid stays high across back-to-back beats and only drops in a gap.
	task automatic send_command(input logic [15:0] speed, input logic [15:0] rate);
		logic [143:0] beat;
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= 32'($urandom());
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {rate, speed};
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			integrate_pose(speed, rate, beat);
			pose_queue.push_back(beat);
		end
	endtask

	// Lowers tvalid and waits until every pose beat is out and the block is idle.
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pose_queue.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_time_step(input logic [15:0] value);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		pose_ts = value;
	endtask

	function automatic logic [15:0] rand_word();
		return 16'($urandom());
	endfunction

	// Extremes of both fields, a zero time step, full-scale turning that
	// wraps the heading, and the smallest and largest time steps.
	task automatic test_directed();
		send_command(16'h0000, 16'h0000);
		send_command(16'h7FFF, 16'h0000);
		send_command(16'h8000, 16'h0000);
		send_command(16'h0000, 16'h7FFF);
		send_command(16'h0000, 16'h8000);
		repeat (3) send_command(16'd256, 16'd4096);
		write_time_step(16'd0);
		send_command(16'h7FFF, 16'h7FFF);
		send_command(16'h8000, 16'h8000);
		write_time_step(16'd1);
		send_command(16'h7FFF, 16'h8000);
		send_command(16'hFFFF, 16'hFFFF);
		write_time_step(16'hFFFF);
		repeat (5) send_command(16'h7FFF, 16'h7FFF);
		repeat (4) send_command(16'h8000, 16'h8000);
	endtask

	// Turns the heading back near zero, then drives full speed straight ahead
	// until the x position saturates and stays pinned.
	task automatic test_position_saturation();
		longint need;
		logic [15:0] speed;
		logic [15:0] rate;
		begin
			write_time_step(16'hFFFF);
			// One rate unit at this time step is about 166877 heading units.
			need = -(longint'($signed(pose_heading)) / 166877);
			send_command(16'h0000, 16'(need));
			for (int i = 0; i < 330; i++) begin
				speed = 16'h7FFF;
				rate = 16'h0000;
				if ($urandom_range(9) == 0)
					speed = rand_word() & 16'h7FFF;
				if ($urandom_range(19) == 0)
					rate = 16'($signed($urandom_range(14)) - 7);
				send_command(speed, rate);
			end
		end
	endtask

	task automatic test_random_phase(input int unsigned idle_pct,
			input int unsigned stall_pct, input logic [15:0] ts, input int count);
		write_time_step(ts);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			send_command(rand_word(), rand_word());
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// The receiver stops for a long stretch while commands keep coming, so
	// the block backs up and holds off its input.
	task automatic test_backpressure();
		write_time_step(16'(TsReset));
		hold_cycles = 2000;
		for (int i = 0; i < 30; i++)
			send_command(rand_word(), rand_word());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		pose_x = 0;
		pose_y = 0;
		pose_heading = '0;
		pose_ts = 16'(TsReset);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_position_saturation();
		test_random_phase(84, 0, 16'd1, 60);
		test_random_phase(0, 84, rand_word() | 16'd1, 60);
		test_random_phase(35, 35, 16'hFFFF, 60);
		test_backpressure();

		drain_block();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
